### rtl/lpfd_pkg.sv
package lpfd_pkg;

  // Parser phase: which part of the message the next byte belongs to
  typedef enum logic [1:0] {
    PH_COUNT   = 2'd0,
    PH_SIZE    = 2'd1,
    PH_PAYLOAD = 2'd2,
    PH_ERROR   = 2'd3
  } phase_t;

  // Class reported with every byte
  typedef enum logic [1:0] {
    CLS_COUNT   = 2'd0,
    CLS_SIZE    = 2'd1,
    CLS_PAYLOAD = 2'd2,
    CLS_DISCARD = 2'd3
  } byte_class_t;

  // Width of the assembled header value
  localparam int unsigned FIELD_W = 32;
  // Header bytes that contribute to the value; later ones are ignored
  localparam int unsigned FIELD_BYTES = FIELD_W / 8;

  // One result transaction
  typedef struct packed {
    byte_class_t          byte_class;
    logic [7:0]           data_out;
    logic [FIELD_W-1:0]   frame_number;
    logic                 frame_done;
    logic                 message_done;
    logic                 zero_count_error;
  } result_t;

endpackage

### rtl/length_prefixed_frame_deframer.sv
// Channel  | Handshake          | Payload
// ---------+--------------------+------------------------------------------------
// in       | in_valid/in_stall  | in_rx_byte
// out      | out_valid/out_stall| out_byte_class, out_data_out, out_frame_number,
//          |                    | out_frame_done, out_message_done,
//          |                    | out_zero_count_error
//
// One byte per cycle while out_stall is low; a byte's result reaches the out ports
// through the input register, then parser logic into the result register.
// The parser state advances only when a byte moves into the result register.
// Reset (rst_n low, synchronous) empties both registers and returns the parser
// to waiting for a frame count; a zero frame count locks it in discard until
// reset. out_stall backs up through the result and input registers to in_stall.
module length_prefixed_frame_deframer #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_byte_class,
  output logic [7:0]  out_data_out,
  output logic [31:0] out_frame_number,
  output logic        out_frame_done,
  output logic        out_message_done,
  output logic        out_zero_count_error
);

  logic              stage_valid;
  logic [7:0]        stage_byte;
  logic              out_ready;
  logic              advance;
  lpfd_pkg::result_t parse_res;
  lpfd_pkg::result_t res_r;
  lpfd_pkg::phase_t  phase;

  // Move a byte through the parser when the result register can take it
  assign advance = stage_valid && out_ready;

  lpfd_in_reg u_in_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_rx_byte (in_rx_byte),
    .take       (out_ready),
    .valid_r    (stage_valid),
    .byte_r     (stage_byte)
  );

  lpfd_parser #(
    .HEADER_BYTES (HEADER_BYTES)
  ) u_parser (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .rx_byte (stage_byte),
    .res     (parse_res),
    .phase   (phase)
  );

  lpfd_out_reg u_out_reg (
    .clk        (clk),
    .rst_n      (rst_n),
    .load_valid (stage_valid),
    .load_res   (parse_res),
    .ready      (out_ready),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .res_r      (res_r)
  );

  // Drive the result ports
  assign out_byte_class       = res_r.byte_class;
  assign out_data_out         = res_r.data_out;
  assign out_frame_number     = res_r.frame_number;
  assign out_frame_done       = res_r.frame_done;
  assign out_message_done     = res_r.message_done;
  assign out_zero_count_error = res_r.zero_count_error;

  // A message ends only on a byte that also ends a frame
  a_msg_implies_frame: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_message_done |-> out_frame_done)
    else $error("message_done without frame_done");

  // A zero frame count leaves the parser in discard
  a_zero_count_locks: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_zero_count_error |-> phase == lpfd_pkg::PH_ERROR)
    else $error("zero frame count did not lock the parser");

  // Once in discard the parser never leaves it before reset
  a_error_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    phase == lpfd_pkg::PH_ERROR |=> phase == lpfd_pkg::PH_ERROR)
    else $error("parser left discard without reset");

  // The input side stalls only while a byte is waiting in the input register
  a_stall_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> stage_valid && out_valid && out_stall)
    else $error("input stalled with no backed-up byte");

endmodule

### rtl/lpfd_in_reg.sv
module lpfd_in_reg (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] in_rx_byte,
  input  logic       take,
  output logic       valid_r,
  output logic [7:0] byte_r
);

  // Hold the byte while it waits for the parser
  assign in_stall = valid_r && !take;

  // Track occupancy of the input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (!in_stall) begin
      valid_r <= in_valid;
    end
  end

  // Load a new byte whenever the register is free or being drained
  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      byte_r <= in_rx_byte;
    end
  end

endmodule

### rtl/lpfd_parser.sv
module lpfd_parser #(
  parameter int unsigned HEADER_BYTES = 4
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 advance,
  input  logic [7:0]           rx_byte,
  output lpfd_pkg::result_t    res,
  output lpfd_pkg::phase_t     phase
);

  localparam int unsigned PW = (HEADER_BYTES > 1) ? $clog2(HEADER_BYTES) : 1;
  localparam int unsigned FW = lpfd_pkg::FIELD_W;
  localparam logic [PW-1:0] POS_LAST = PW'(HEADER_BYTES - 1);

  lpfd_pkg::phase_t phase_r, phase_nxt;
  logic [PW-1:0]    pos_r, pos_nxt;
  logic [FW-1:0]    frames_r, frames_nxt;
  logic [FW-1:0]    len_r, len_nxt;
  logic [FW-1:0]    idx_r, idx_nxt;
  logic [FW-1:0]    seen_r, seen_nxt;

  logic [PW-1:0]    pos_inc;
  logic             last_hdr;
  logic [FW-1:0]    cnt_acc;
  logic [FW-1:0]    len_acc;
  logic [FW-1:0]    idx_inc;
  logic [FW-1:0]    seen_inc;
  logic             close_frm;

  // OR a header byte into its little-endian lane; bytes past the fourth drop
  function automatic logic [FW-1:0] put_byte(input logic [FW-1:0] acc,
                                             input logic [PW-1:0] pos,
                                             input logic [7:0]    b);
    logic [FW-1:0] r;
    r = acc;
    for (int k = 0; k < lpfd_pkg::FIELD_BYTES; k++) begin
      if ({{(8-PW){1'b0}}, pos} == 8'(k)) begin
        r[8*k +: 8] = acc[8*k +: 8] | b;
      end
    end
    return r;
  endfunction

  assign pos_inc  = pos_r + 1'b1;
  assign last_hdr = (pos_r == POS_LAST);
  assign cnt_acc  = put_byte(frames_r, pos_r, rx_byte);
  assign len_acc  = put_byte(len_r, pos_r, rx_byte);
  assign idx_inc  = idx_r + 1'b1;
  assign seen_inc = seen_r + 1'b1;
  assign phase    = phase_r;

  // Classify the byte and work out the next parser state
  always_comb begin
    phase_nxt  = phase_r;
    pos_nxt    = pos_r;
    frames_nxt = frames_r;
    len_nxt    = len_r;
    idx_nxt    = idx_r;
    seen_nxt   = seen_r;
    close_frm  = 1'b0;

    res                  = '0;
    res.byte_class       = lpfd_pkg::CLS_DISCARD;
    res.data_out         = rx_byte;

    unique case (phase_r)
      lpfd_pkg::PH_COUNT: begin
        res.byte_class = lpfd_pkg::CLS_COUNT;
        frames_nxt     = cnt_acc;
        pos_nxt        = pos_inc;
        if (last_hdr) begin
          pos_nxt = '0;
          if (cnt_acc == '0) begin
            res.zero_count_error = 1'b1;
            phase_nxt            = lpfd_pkg::PH_ERROR;
          end else begin
            phase_nxt = lpfd_pkg::PH_SIZE;
            idx_nxt   = '0;
            len_nxt   = '0;
            seen_nxt  = '0;
          end
        end
      end
      lpfd_pkg::PH_SIZE: begin
        res.byte_class   = lpfd_pkg::CLS_SIZE;
        res.frame_number = idx_r;
        len_nxt          = len_acc;
        pos_nxt          = pos_inc;
        if (last_hdr) begin
          pos_nxt  = '0;
          seen_nxt = '0;
          if (len_acc == '0) begin
            close_frm = 1'b1;
          end else begin
            phase_nxt = lpfd_pkg::PH_PAYLOAD;
          end
        end
      end
      lpfd_pkg::PH_PAYLOAD: begin
        res.byte_class   = lpfd_pkg::CLS_PAYLOAD;
        res.frame_number = idx_r;
        seen_nxt         = seen_inc;
        if (seen_inc >= len_r) begin
          close_frm = 1'b1;
        end
      end
      lpfd_pkg::PH_ERROR: begin
        res.byte_class = lpfd_pkg::CLS_DISCARD;
      end
      default: begin
        res.byte_class = lpfd_pkg::CLS_DISCARD;
      end
    endcase

    // Close the frame; end the message after its last frame
    if (close_frm) begin
      res.frame_done = 1'b1;
      idx_nxt        = idx_inc;
      seen_nxt       = '0;
      pos_nxt        = '0;
      len_nxt        = '0;
      if (idx_inc == frames_r) begin
        res.message_done = 1'b1;
        phase_nxt        = lpfd_pkg::PH_COUNT;
        frames_nxt       = '0;
        idx_nxt          = '0;
      end else begin
        phase_nxt = lpfd_pkg::PH_SIZE;
      end
    end
  end

  // Advance the state once per processed byte
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= lpfd_pkg::PH_COUNT;
      pos_r    <= '0;
      frames_r <= '0;
      len_r    <= '0;
      idx_r    <= '0;
      seen_r   <= '0;
    end else if (advance) begin
      phase_r  <= phase_nxt;
      pos_r    <= pos_nxt;
      frames_r <= frames_nxt;
      len_r    <= len_nxt;
      idx_r    <= idx_nxt;
      seen_r   <= seen_nxt;
    end
  end

endmodule

### rtl/lpfd_out_reg.sv
module lpfd_out_reg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              load_valid,
  input  lpfd_pkg::result_t load_res,
  output logic              ready,
  output logic              out_valid,
  input  logic              out_stall,
  output lpfd_pkg::result_t res_r
);

  // Accept a new result when empty or when the held one leaves
  assign ready = !out_valid || !out_stall;

  // Track occupancy of the result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (ready) begin
      out_valid <= load_valid;
    end
  end

  // Capture the result payload
  always_ff @(posedge clk) begin
    if (ready && load_valid) begin
      res_r <= load_res;
    end
  end

endmodule
